>>> rtl/signed_int_to_decimal_ascii_top_assert.svh
// Assertion macros for the signed integer to decimal text block.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off during reset.
`define SIDTA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sidta assertion failed");
// Next-cycle implication, sampled on clk, off during reset.
`define SIDTA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sidta assertion failed");
`else
`define SIDTA_ASSERT_IMPL(label, ante, cons)
`define SIDTA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/sidta_pkg.sv
// Package: widths, character codes and status type for the decimal text block.
`timescale 1ns / 1ps
package sidta_pkg;
  localparam int VALUE_BITS = 32;
  // decimal digits of 2^(VALUE_BITS-1), via log10(2)
  localparam int DIGITS     = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int BCD_BITS   = DIGITS * 4;
  localparam int CNT_W      = $clog2(VALUE_BITS);
  localparam int DCNT_W     = $clog2(DIGITS + 1);
  localparam int CHAR_BITS  = 6;

  localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 6'd48;
  localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 6'd45;

  typedef struct packed {
    logic done;
    logic neg;
  } conv_status_t;
endpackage

>>> rtl/sidta_bcd_conv.sv
// Bit-serial binary to BCD converter (shift and add 3), one bit per cycle.
`timescale 1ns / 1ps
module sidta_bcd_conv (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      start,
  input  logic signed [sidta_pkg::VALUE_BITS-1:0]   value,
  output logic [sidta_pkg::BCD_BITS-1:0]            bcd,
  output sidta_pkg::conv_status_t                   status
);
  import sidta_pkg::*;

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic                  neg_r, neg_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic [BCD_BITS-1:0]   bcd_r, bcd_nxt;
  logic [BCD_BITS-1:0]   adj;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_r[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd_r[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = bcd_r[i*4 +: 4];
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    mag_nxt  = mag_r;
    bcd_nxt  = bcd_r;
    if (start) begin
      busy_nxt = 1'b1;
      neg_nxt  = value[VALUE_BITS-1];
      mag_nxt  = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
      bcd_nxt  = '0;
      cnt_nxt  = CNT_W'(VALUE_BITS - 1);
    end else if (busy_r) begin
      bcd_nxt = {adj[BCD_BITS-2:0], mag_r[VALUE_BITS-1]};
      mag_nxt = {mag_r[VALUE_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
  end

  assign bcd         = bcd_r;
  assign status.done = done_r;
  assign status.neg  = neg_r;
endmodule

>>> rtl/signed_int_to_decimal_ascii_top.sv
// Top level: signed integer to decimal ASCII text, one character per word.
//
//   channel | ports                              | direction
//   in      | in_valid, in_stall, in_value       | value words in
//   out     | out_valid, out_stall, out_character, out_last | text words out
//
// An item is converted to BCD one bit at a time, then its leading zeros are
// dropped, then its characters (1 to 11) are sent, one per output word.
// The bit-serial BCD converter takes the bulk of the time for an item.
// Synchronous active-low reset returns to idle and drops out_valid.
// in_stall is high while an item is in work; the output register holds
// a stalled word and the next character waits behind it.
`timescale 1ns / 1ps
`include "signed_int_to_decimal_ascii_top_assert.svh"
module signed_int_to_decimal_ascii_top (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [sidta_pkg::VALUE_BITS-1:0] in_value,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [sidta_pkg::CHAR_BITS-1:0]         out_character,
  output logic                                    out_last
);
  import sidta_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_t;

  state_t                state_r;
  logic [BCD_BITS-1:0]   digits_r;
  logic [DCNT_W-1:0]     left_r;
  logic                  sign_r;
  logic                  out_valid_r;
  logic [CHAR_BITS-1:0]  out_character_r;
  logic                  out_last_r;

  logic                  start;
  logic [BCD_BITS-1:0]   bcd;
  conv_status_t          status;
  logic [3:0]            top_digit;
  logic                  out_free;

  assign start     = in_valid && !in_stall;
  assign top_digit = digits_r[BCD_BITS-1 -: 4];
  assign out_free  = !out_valid_r || !out_stall;

  sidta_bcd_conv u_conv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .value  (in_value),
    .bcd    (bcd),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != ST_EMIT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (status.done) begin
            digits_r <= bcd;
            sign_r   <= status.neg;
            left_r   <= DCNT_W'(DIGITS);
            state_r  <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          if (top_digit == 4'd0 && left_r > DCNT_W'(1)) begin
            digits_r <= {digits_r[BCD_BITS-5:0], 4'd0};
            left_r   <= left_r - 1'b1;
          end else begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (sign_r) begin
              sign_r          <= 1'b0;
              out_character_r <= ASCII_MINUS;
              out_last_r      <= 1'b0;
            end else begin
              out_character_r <= ASCII_ZERO + {2'b00, top_digit};
              out_last_r      <= (left_r == DCNT_W'(1));
              digits_r        <= {digits_r[BCD_BITS-5:0], 4'd0};
              left_r          <= left_r - 1'b1;
              if (left_r == DCNT_W'(1)) begin
                state_r <= ST_IDLE;
              end
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_last      = out_last_r;

  `SIDTA_ASSERT_IMPL(a_minus_not_last, out_valid_r && out_character_r == ASCII_MINUS, !out_last_r)
  `SIDTA_ASSERT_NEXT(a_accept_to_conv, start, state_r == ST_CONV)
  `SIDTA_ASSERT_IMPL(a_emit_has_digits, state_r == ST_EMIT, left_r != '0)
  `SIDTA_ASSERT_IMPL(a_done_only_in_conv, status.done, state_r == ST_CONV)
endmodule
